// File: design/run_length_encoder_doubled_symbol_unit_defines.svh
// Assertion helpers used by the top-level RTL.
`ifndef RUN_LENGTH_ENCODER_DOUBLED_SYMBOL_UNIT_DEFINES_SVH
`define RUN_LENGTH_ENCODER_DOUBLED_SYMBOL_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLDS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define RLDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/rlds_pkg.sv
package rlds_pkg;

  localparam int RLDS_MAX_RUN = 255;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_message;
  } rlds_in_t;

  typedef struct packed {
    logic [7:0] run_symbol;
    logic       doubled;
    logic [7:0] run_length;
    logic       message_done;
  } rlds_out_t;

  // results produced by one transaction; second only with first
  typedef struct packed {
    logic first;
    logic second;
  } rlds_push_t;

endpackage

// File: design/run_length_encoder_doubled_symbol_unit.sv
// Byte-stream run-length encoder. One byte is taken per cycle while in_stall is
// low; a run closes on a different byte, on a byte that would push it past its
// cap of min(MAX_RUN, 255), or on a byte marked end_of_message, which also
// flushes the run holding that byte with message_done set. An accepted byte is
// registered in the input stage (in_r); its results are then written into the
// result queue, a second one together with the first, and each is presented
// once the results ahead of it have left. The output side delivers one result
// per cycle while out_stall is low, from an 8-entry result queue. The input
// stalls only when that queue cannot absorb two results for every transaction
// in flight, so the sustained rate is one byte per cycle as long as the output
// is not stalled and the stream does not average more than one result per byte.
`include "run_length_encoder_doubled_symbol_unit_defines.svh"

module run_length_encoder_doubled_symbol_unit #(
  parameter int MAX_RUN = rlds_pkg::RLDS_MAX_RUN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlds_pkg::rlds_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rlds_pkg::rlds_out_t out_data
);
  import rlds_pkg::*;

  logic               acc;
  logic               stage_vld;
  rlds_push_t         push;
  rlds_out_t          res0, res1;
  logic               pop;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW:0]   reserved;

  // room for two results of the staged transaction and two of a new one
  assign reserved  = {1'b0, count} + {{(FIFO_CW-1){1'b0}}, stage_vld, 1'b0};
  assign in_stall  = reserved > (FIFO_CW+1)'(FIFO_DEPTH - 2);
  assign acc       = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;

  rlds_encode #(
    .MAX_RUN(MAX_RUN)
  ) u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_data  (in_data),
    .stage_vld(stage_vld),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  rlds_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata0(res0),
    .wdata1(res1),
    .pop   (pop),
    .count (count),
    .head  (out_data)
  );

  `RLDS_ASSERT_NOW(a_no_overflow, 1'b1, count <= FIFO_CW'(FIFO_DEPTH))
  `RLDS_ASSERT_NOW(a_second_needs_first, push.second, push.first)
  `RLDS_ASSERT_NOW(a_doubled_len, out_valid, out_data.doubled == (out_data.run_length > 8'd1))
  `RLDS_ASSERT_NEXT(a_stage_follows, acc, stage_vld)

endmodule

// File: design/rlds_encode.sv
module rlds_encode #(
  parameter int MAX_RUN = rlds_pkg::RLDS_MAX_RUN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  rlds_pkg::rlds_in_t  in_data,
  output logic              stage_vld,
  output rlds_pkg::rlds_push_t push,
  output rlds_pkg::rlds_out_t  res0,
  output rlds_pkg::rlds_out_t  res1
);
  import rlds_pkg::*;

  localparam int RUN_CAP_I = (MAX_RUN > 255) ? 255 : MAX_RUN;
  localparam logic [7:0] RUN_CAP = 8'(RUN_CAP_I);

  rlds_in_t   in_r;
  logic       sv_r;
  logic [7:0] held_r, held_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       open_r, open_nxt;

  logic       cont;
  logic [7:0] run_sym, run_cnt;

  always_ff @(posedge clk) begin
    if (acc) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r   <= 1'b0;
      held_r <= '0;
      cnt_r  <= '0;
      open_r <= 1'b0;
    end else begin
      sv_r   <= acc;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
      open_r <= open_nxt;
    end
  end

  always_comb begin
    cont    = open_r && (in_r.symbol == held_r) && (cnt_r < RUN_CAP);
    run_sym = cont ? held_r : in_r.symbol;
    run_cnt = cont ? (cnt_r + 8'd1) : 8'd1;

    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    if (sv_r) begin
      if (in_r.end_of_message) begin
        held_nxt = '0;
        cnt_nxt  = '0;
        open_nxt = 1'b0;
      end else begin
        held_nxt = run_sym;
        cnt_nxt  = run_cnt;
        open_nxt = 1'b1;
      end
    end
  end

  logic       close_vld;
  rlds_out_t  close_res, flush_res;

  always_comb begin
    close_vld = !cont && open_r;

    close_res.run_symbol   = held_r;
    close_res.doubled      = (cnt_r > 8'd1);
    close_res.run_length   = cnt_r;
    close_res.message_done = 1'b0;

    flush_res.run_symbol   = run_sym;
    flush_res.doubled      = (run_cnt > 8'd1);
    flush_res.run_length   = run_cnt;
    flush_res.message_done = 1'b1;

    // pack results into the first free slots
    push.first  = sv_r && (close_vld || in_r.end_of_message);
    push.second = sv_r && close_vld && in_r.end_of_message;
    res0        = close_vld ? close_res : flush_res;
    res1        = flush_res;
  end

  assign stage_vld = sv_r;

endmodule

// File: design/rlds_out_fifo.sv
module rlds_out_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rlds_pkg::rlds_push_t        push,
  input  rlds_pkg::rlds_out_t         wdata0,
  input  rlds_pkg::rlds_out_t         wdata1,
  input  logic                        pop,
  output logic [rlds_pkg::FIFO_CW-1:0] count,
  output rlds_pkg::rlds_out_t         head
);
  import rlds_pkg::*;

  rlds_out_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt;
  logic [FIFO_AW-1:0] rptr_r, rptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0] wptr_p1;
  logic [FIFO_CW-1:0] n_push;

  always_comb begin
    wptr_p1  = wptr_r + FIFO_AW'(1);
    n_push   = FIFO_CW'(push.first) + FIFO_CW'(push.second);
    wptr_nxt = wptr_r + n_push[FIFO_AW-1:0];
    rptr_nxt = pop ? (rptr_r + FIFO_AW'(1)) : rptr_r;
    cnt_nxt  = cnt_r + n_push - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wptr_r] <= wdata0;
    end
    if (push.second) begin
      mem_r[wptr_p1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign count = cnt_r;
  assign head  = mem_r[rptr_r];

endmodule
